/* src/sbeq_pkg.sv */
`default_nettype none

package sbeq_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 32;
  localparam int SIG_WIDTH    = SAMPLE_WIDTH + 8;
  localparam int DLY_WIDTH    = SAMPLE_WIDTH + 16;
  localparam int NUM_COEFS    = 5;
  localparam int PROD_SHIFT   = COEF_WIDTH - 4 - 8;
  localparam int PROD_WIDTH   = SIG_WIDTH + COEF_WIDTH - PROD_SHIFT;
  localparam int Y_SHIFT      = DLY_WIDTH - SIG_WIDTH;

  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  // 1.0 in the coefficient format
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << (COEF_WIDTH - 4));

  typedef struct packed {
    logic                           mode;
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
    logic                           block_end;
    logic [3:0]                     band_index;
    logic [2:0]                     coef_select;
    logic signed [COEF_WIDTH-1:0]   coef_value;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
    logic                           left_clipped;
    logic                           right_clipped;
    logic                           block_end_out;
  } result_t;

endpackage

`default_nettype wire

/* src/sbeq_ram.sv */
`default_nettype none

module sbeq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/sbeq_mul.sv */
`default_nettype none

module sbeq_mul
  import sbeq_pkg::*;
(
  input  logic                         clk,
  input  logic signed [SIG_WIDTH-1:0]  a,
  input  logic signed [COEF_WIDTH-1:0] b,
  output logic signed [PROD_WIDTH-1:0] p
);

  localparam int MW = SIG_WIDTH + COEF_WIDTH;

  logic signed [MW-1:0] mreg;
  logic signed [MW-1:0] rnd;

  // round half up, then drop the extra fraction bits
  assign rnd = (mreg + (MW'(1) <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;

  always_ff @(posedge clk) begin
    mreg <= a * b;
    p    <= rnd[PROD_WIDTH-1:0];
  end

endmodule

`default_nettype wire

/* src/stereo_biquad_eq_cascade_core.sv */
`default_nettype none

// Stereo equalizer: each channel of a frame runs through BAND_COUNT transposed
// direct form II biquads on one shared 32x32 multiplier with a two-register
// rounding pipeline. A section steps from the fetch through the five products
// (the feedback products wait on the section output) to the delay write;
// channels run one after the other, so a frame is accepted, computed, and then
// moved into the output register as soon as that register is free; the next
// item is taken only once the core is idle again, so a new frame is not accepted
// before the last result is loaded. A coefficient write (mode 1) is taken only
// while idle and gives no result; writes to a band or selector out of
// range are dropped. Coefficients and delay state live in RAMs; per-entry
// valid bits cleared at reset give the pass-through coefficients (b0 = 1.0)
// and zero delays, so no clearing pass is needed.
module stereo_biquad_eq_cascade_core
  import sbeq_pkg::*;
#(
  parameter int BAND_COUNT = 12
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int NUM_ENT = BAND_COUNT * NUM_COEFS;
  localparam int CA_W    = $clog2(NUM_ENT);
  localparam int DR      = BAND_COUNT * 2;
  localparam int DA_W    = $clog2(DR);
  localparam int BAND_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int ACC_W   = PROD_WIDTH + 1;
  localparam int RW      = ACC_W - Y_SHIFT;
  localparam int T_W     = PROD_WIDTH + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [3:0] STEP_FETCH  = 4'd0;
  localparam logic [3:0] STEP_MUL_B0 = 4'd1;
  localparam logic [3:0] STEP_MUL_B1 = 4'd2;
  localparam logic [3:0] STEP_MUL_B2 = 4'd3;
  localparam logic [3:0] STEP_Y      = 4'd4;
  localparam logic [3:0] STEP_MUL_A1 = 4'd5;
  localparam logic [3:0] STEP_MUL_A2 = 4'd6;
  localparam logic [3:0] STEP_SUB_A1 = 4'd7;
  localparam logic [3:0] STEP_SUB_A2 = 4'd8;
  localparam logic [3:0] STEP_WRITE  = 4'd9;

  function automatic logic [SIG_WIDTH-1:0] sat_sig(input logic [RW-1:0] v);
    logic [RW-SIG_WIDTH:0] hi;
    hi = v[RW-1:SIG_WIDTH-1];
    if (&hi || ~|hi) begin
      return v[SIG_WIDTH-1:0];
    end
    return {v[RW-1], {(SIG_WIDTH-1){~v[RW-1]}}};
  endfunction

  function automatic logic [DLY_WIDTH-1:0] sat_dly(input logic [T_W-1:0] v);
    logic [T_W-DLY_WIDTH:0] hi;
    hi = v[T_W-1:DLY_WIDTH-1];
    if (&hi || ~|hi) begin
      return v[DLY_WIDTH-1:0];
    end
    return {v[T_W-1], {(DLY_WIDTH-1){~v[T_W-1]}}};
  endfunction

  function automatic logic out_clip(input logic [SIG_WIDTH-1:0] v);
    logic [SIG_WIDTH-SAMPLE_WIDTH:0] hi;
    hi = v[SIG_WIDTH-1:SAMPLE_WIDTH-1];
    return !(&hi || ~|hi);
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] sat_out(input logic [SIG_WIDTH-1:0] v);
    if (out_clip(v)) begin
      return {v[SIG_WIDTH-1], {(SAMPLE_WIDTH-1){~v[SIG_WIDTH-1]}}};
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  logic [1:0]        state;
  logic [3:0]        step;
  logic [BAND_W-1:0] band;
  logic              chan;
  logic              last_band;

  logic signed [SIG_WIDTH-1:0]    x;
  logic signed [SIG_WIDTH-1:0]    y;
  logic signed [SIG_WIDTH-1:0]    left_res;
  logic signed [SIG_WIDTH-1:0]    mul_a;
  logic signed [SAMPLE_WIDTH-1:0] right_hold;
  logic                           end_hold;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_rnd;
  logic signed [T_W-1:0]          t1;
  logic signed [T_W-1:0]          t2;
  logic signed [DLY_WIDTH-1:0]    z1;
  logic signed [DLY_WIDTH-1:0]    z2;
  logic signed [PROD_WIDTH-1:0]   prod;

  logic                         coef_we;
  logic [CA_W-1:0]              coef_waddr;
  logic [8:0]                   wa_full;
  logic                         coef_re;
  logic [2:0]                   rsel;
  logic [CA_W-1:0]              coef_raddr;
  logic [COEF_WIDTH-1:0]        coef_rdata;
  logic signed [COEF_WIDTH-1:0] coef_q;
  logic [NUM_ENT-1:0]           coef_valid;
  logic                         rd_cvalid;
  logic                         rd_isb0;

  logic                   dly_we;
  logic                   dly_re;
  logic [BAND_W:0]        row_full;
  logic [DA_W-1:0]        dly_row;
  logic [2*DLY_WIDTH-1:0] dly_wdata;
  logic [2*DLY_WIDTH-1:0] dly_rdata;
  logic [DR-1:0]          dly_valid;
  logic                   rd_dvalid;

  logic take;
  logic frame_take;
  logic load_result;

  assign item_stall  = rst || (state != ST_IDLE);
  assign take        = item_valid && !item_stall;
  assign frame_take  = take && !item.mode;
  assign load_result = (state == ST_DONE) && (!result_valid || !result_stall);
  assign last_band   = (band == BAND_W'(BAND_COUNT - 1));

  // coefficient writes land in the store at transfer time
  assign wa_full    = 9'(item.band_index) * 9'(NUM_COEFS) + 9'(item.coef_select);
  assign coef_waddr = wa_full[CA_W-1:0];
  assign coef_we    = take && item.mode &&
                      ({2'b00, item.band_index} < 6'(BAND_COUNT)) &&
                      (item.coef_select <= COEF_A2);

  assign coef_raddr = CA_W'(band) * CA_W'(NUM_COEFS) + CA_W'(rsel);
  assign row_full   = {band, chan};
  assign dly_row    = row_full[DA_W-1:0];
  assign dly_wdata  = {sat_dly(t2), sat_dly(t1)};

  assign coef_q  = rd_cvalid ? $signed(coef_rdata) : (rd_isb0 ? COEF_ONE : '0);
  assign mul_a   = (step >= STEP_MUL_A1) ? y : x;
  assign acc_rnd = acc + (ACC_W'(1) <<< (Y_SHIFT - 1));

  always_comb begin
    coef_re = 1'b0;
    rsel    = COEF_B0;
    dly_re  = 1'b0;
    dly_we  = 1'b0;
    if (state == ST_RUN) begin
      case (step)
        STEP_FETCH: begin
          coef_re = 1'b1;
          rsel    = COEF_B0;
          dly_re  = 1'b1;
        end
        STEP_MUL_B0: begin
          coef_re = 1'b1;
          rsel    = COEF_B1;
        end
        STEP_MUL_B1: begin
          coef_re = 1'b1;
          rsel    = COEF_B2;
        end
        STEP_Y: begin
          coef_re = 1'b1;
          rsel    = COEF_A1;
        end
        STEP_MUL_A1: begin
          coef_re = 1'b1;
          rsel    = COEF_A2;
        end
        STEP_WRITE: begin
          dly_we = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  sbeq_ram #(
    .WIDTH(COEF_WIDTH),
    .DEPTH(NUM_ENT)
  ) u_coef_ram (
    .clk  (clk),
    .we   (coef_we),
    .waddr(coef_waddr),
    .wdata(item.coef_value),
    .re   (coef_re),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  sbeq_ram #(
    .WIDTH(2 * DLY_WIDTH),
    .DEPTH(DR)
  ) u_dly_ram (
    .clk  (clk),
    .we   (dly_we),
    .waddr(dly_row),
    .wdata(dly_wdata),
    .re   (dly_re),
    .raddr(dly_row),
    .rdata(dly_rdata)
  );

  sbeq_mul u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (coef_q),
    .p  (prod)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= STEP_FETCH;
      band         <= '0;
      chan         <= 1'b0;
      result_valid <= 1'b0;
      coef_valid   <= '0;
      dly_valid    <= '0;
    end else begin
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (coef_we) begin
        coef_valid[coef_waddr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (frame_take) begin
            state <= ST_RUN;
            step  <= STEP_FETCH;
            band  <= '0;
            chan  <= 1'b0;
          end
        end
        ST_RUN: begin
          if (step == STEP_WRITE) begin
            step               <= STEP_FETCH;
            dly_valid[dly_row] <= 1'b1;
            if (!last_band) begin
              band <= band + 1'b1;
            end else if (!chan) begin
              band <= '0;
              chan <= 1'b1;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DONE: begin
          if (load_result) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (coef_re) begin
      rd_cvalid <= coef_valid[coef_raddr];
      rd_isb0   <= (rsel == COEF_B0);
    end
    if (dly_re) begin
      rd_dvalid <= dly_valid[dly_row];
    end
    if (frame_take) begin
      x          <= SIG_WIDTH'(item.left_sample);
      right_hold <= item.right_sample;
      end_hold   <= item.block_end;
    end
    if (state == ST_RUN) begin
      case (step)
        STEP_MUL_B0: begin
          z1 <= rd_dvalid ? $signed(dly_rdata[DLY_WIDTH-1:0]) : '0;
          z2 <= rd_dvalid ? $signed(dly_rdata[2*DLY_WIDTH-1:DLY_WIDTH]) : '0;
        end
        STEP_MUL_B2: begin
          acc <= ACC_W'(prod) + ACC_W'(z1);
        end
        STEP_Y: begin
          t1 <= T_W'(prod) + T_W'(z2);
          y  <= $signed(sat_sig(acc_rnd[ACC_W-1:Y_SHIFT]));
        end
        STEP_MUL_A1: begin
          t2 <= T_W'(prod);
        end
        STEP_SUB_A1: begin
          t1 <= t1 - T_W'(prod);
        end
        STEP_SUB_A2: begin
          t2 <= t2 - T_W'(prod);
        end
        STEP_WRITE: begin
          // advance to the next band, or switch to the right channel
          if (last_band && !chan) begin
            left_res <= y;
            x        <= SIG_WIDTH'(right_hold);
          end else begin
            x <= y;
          end
        end
        default: begin
        end
      endcase
    end
    if (load_result) begin
      result.left_out      <= $signed(sat_out(left_res));
      result.right_out     <= $signed(sat_out(y));
      result.left_clipped  <= out_clip(left_res);
      result.right_clipped <= out_clip(y);
      result.block_end_out <= end_hold;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= STEP_WRITE))
    else $error("section step counter out of range");

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (band <= BAND_W'(BAND_COUNT - 1)))
    else $error("band counter out of range");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    frame_take |=> (state == ST_RUN) && (step == STEP_FETCH) && (band == '0) && !chan)
    else $error("frame did not start at the first section");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    load_result |=> (state == ST_IDLE) && result_valid)
    else $error("finished frame not moved to the output register");

  a_delay_write: assert property (@(posedge clk) disable iff (rst)
    dly_we |=> (step == STEP_FETCH) && dly_valid[$past(dly_row)])
    else $error("delay write not followed by a new section");

endmodule

`default_nettype wire
